// ----- src/sfa_pkg.sv -----
// shared types, request codes and slice helpers for the subregister file alu
package sfa_pkg;

  localparam int RegisterBytes = 16;
  localparam int RegBits = RegisterBytes * 8;
  localparam int WordBits = 64;
  localparam int CountBits = $clog2(WordBits);

  typedef enum logic [4:0] {
    REQ_QUERY = 5'd0,
    REQ_CLEAR = 5'd1,
    REQ_LOAD  = 5'd2,
    REQ_MOVE  = 5'd3,
    REQ_SWAP  = 5'd4,
    REQ_SHL   = 5'd5,
    REQ_SHR   = 5'd6,
    REQ_AND   = 5'd7,
    REQ_OR    = 5'd8,
    REQ_XOR   = 5'd9,
    REQ_NOT   = 5'd10,
    REQ_INC   = 5'd11,
    REQ_DEC   = 5'd12,
    REQ_NEG   = 5'd13,
    REQ_ADD   = 5'd14,
    REQ_SUB   = 5'd15,
    REQ_MUL   = 5'd16,
    REQ_DIVU  = 5'd17,
    REQ_DIVS  = 5'd18
  } req_t;

  typedef struct packed {
    logic go;
    logic is_div;
  } sfa_ctl_t;

  function automatic logic [RegBits-1:0] byte_mask(input logic [3:0] size_m1);
    logic [RegBits-1:0] m;
    m = '0;
    for (int i = 0; i < RegisterBytes; i++) begin
      if (i <= int'(size_m1)) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [RegBits-1:0] slice_get(input logic [RegBits-1:0] r,
                                                   input logic [7:0] spec);
    return (r >> {spec[7:4], 3'b000}) & byte_mask(spec[3:0]);
  endfunction

  function automatic logic [RegBits-1:0] slice_put(input logic [RegBits-1:0] r,
                                                   input logic [7:0] spec,
                                                   input logic [RegBits-1:0] buf_in);
    logic [RegBits-1:0] m;
    logic [RegBits-1:0] sh;
    m = byte_mask(spec[3:0]) << {spec[7:4], 3'b000};
    sh = buf_in << {spec[7:4], 3'b000};
    return (r & ~m) | (sh & m);
  endfunction

  function automatic logic [WordBits-1:0] sext_bytes(input logic [WordBits-1:0] v,
                                                     input logic [3:0] size_m1);
    logic [WordBits-1:0] o;
    logic s;
    o = v;
    if (size_m1 < 4'd7) begin
      s = v[{size_m1[2:0], 3'b111}];
      for (int i = 0; i < 8; i++) begin
        if (i > int'(size_m1)) o[i*8 +: 8] = {8{s}};
      end
    end
    return o;
  endfunction

endpackage

// ----- src/subregister_file_alu.sv -----
// top level: 16-byte register file with slice alu
// sequence: exec state, then wait state for a serial mul or divide, then report state before done
// throughput: one request at a time, busy high until the result strobe
// the receiver cannot stall: done marks one cycle of valid result
// reset clears the register bytes and the control state
module subregister_file_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  req_type,
  input  logic [7:0]  first_spec,
  input  logic [7:0]  second_spec,
  input  logic [63:0] load_value,
  output logic        done,
  output logic        first_valid,
  output logic        first_valid_float,
  output logic        slices_overlap,
  output logic        divide_by_zero,
  output logic [63:0] read_data
);
  import sfa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_REPORT} state_t;

  state_t               state;
  logic [RegBits-1:0]   regs;
  logic [4:0]           req;
  logic [7:0]           s1;
  logic [7:0]           s2;
  logic [WordBits-1:0]  load;
  logic                 dz;
  logic                 neg_q;
  logic [WordBits-1:0]  mask_q;

  logic [RegBits-1:0]   b1;
  logic [RegBits-1:0]   b2;
  logic [4:0]           n1;
  logic                 size_ok;
  logic [RegBits-1:0]   mask_full;
  logic [WordBits-1:0]  mask;
  logic [WordBits-1:0]  d;
  logic [WordBits-1:0]  v;
  logic [WordBits-1:0]  ds;
  logic [WordBits-1:0]  vs;
  logic [WordBits-1:0]  ma;
  logic [WordBits-1:0]  mb;
  logic [WordBits-1:0]  r;
  logic [RegBits-1:0]   regs_next;
  logic                 is_alu;
  sfa_ctl_t             ctl;
  logic                 ser_done;
  logic [WordBits-1:0]  ser_res;
  logic [WordBits-1:0]  fin;
  logic [4:0]           p1;
  logic [4:0]           p2;
  logic                 valid1;

  assign busy = (state != S_IDLE);
  assign b1 = slice_get(regs, s1);
  assign b2 = slice_get(regs, s2);
  assign n1 = {1'b0, s1[3:0]} + 5'd1;
  assign size_ok = (s1[3:0] == 4'd0) || (s1[3:0] == 4'd1) || (s1[3:0] == 4'd3)
                   || (s1[3:0] == 4'd7);
  assign mask_full = byte_mask(s1[3:0]);
  assign mask = mask_full[WordBits-1:0];
  assign d = b1[WordBits-1:0] & mask;
  assign v = b2[WordBits-1:0];
  assign ds = sext_bytes(d, s1[3:0]);
  assign vs = sext_bytes(v, s2[3:0]);
  assign ma = ds[WordBits-1] ? -ds : ds;
  assign mb = vs[WordBits-1] ? -vs : vs;
  assign is_alu = (req >= REQ_SHL) && (req <= REQ_DIVS) && size_ok;
  assign p1 = {1'b0, first_spec[7:4]};
  assign p2 = {1'b0, second_spec[7:4]};
  assign valid1 = ((p1 + {1'b0, first_spec[3:0]}) < 5'd16)
                  && ((first_spec[7:4] & first_spec[3:0]) == 4'd0)
                  && ((first_spec[3:0] & (first_spec[3:0] + 4'd1)) == 4'd0)
                  && (first_spec[3:0] != 4'hF);
  assign fin = (neg_q ? -ser_res : ser_res) & mask_q;

  always_comb begin
    r = d;
    case (req)
      REQ_SHL: r = (v >= WordBits'(n1) << 3) ? '0 : d << v[5:0];
      REQ_SHR: r = (v >= WordBits'(n1) << 3) ? '0 : d >> v[5:0];
      REQ_AND: r = d & v;
      REQ_OR:  r = d | v;
      REQ_XOR: r = d ^ v;
      REQ_NOT: r = ~d;
      REQ_INC: r = d + 1'b1;
      REQ_DEC: r = d - 1'b1;
      REQ_NEG: r = -d;
      REQ_ADD: r = d + v;
      REQ_SUB: r = d - v;
      default: r = d;
    endcase
  end

  always_comb begin
    regs_next = regs;
    case (req)
      REQ_CLEAR: regs_next = slice_put(regs, s1, '0);
      REQ_LOAD:  regs_next = slice_put(regs, s1, {{(RegBits-WordBits){1'b0}}, load});
      REQ_MOVE:  regs_next = slice_put(regs, s2, b1);
      REQ_SWAP:  regs_next = slice_put(slice_put(regs, s1, b2), s2, b1);
      default: begin
        if (is_alu)
          regs_next = slice_put(regs, s1, {{(RegBits-WordBits){1'b0}}, r & mask});
      end
    endcase
  end

  always_comb begin
    ctl.go = 1'b0;
    ctl.is_div = (req != REQ_MUL);
    if (state == S_EXEC && is_alu) begin
      if (req == REQ_MUL) ctl.go = 1'b1;
      else if (req == REQ_DIVU) ctl.go = (v != '0);
      else if (req == REQ_DIVS) ctl.go = (vs != '0);
    end
  end

  sfa_serial u_serial (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .a      ((req == REQ_DIVS) ? ma : d),
    .b      ((req == REQ_DIVS) ? mb : v),
    .done   (ser_done),
    .result (ser_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      regs <= '0;
      done <= 1'b0;
      dz <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req <= req_type;
            s1 <= first_spec;
            s2 <= second_spec;
            load <= load_value;
            dz <= 1'b0;
            first_valid <= valid1;
            first_valid_float <= valid1 && (first_spec[3:0] >= 4'd3);
            slices_overlap <= (p1 < p2) ? ((p1 + {1'b0, first_spec[3:0]}) >= p2)
                                        : ((p2 + {1'b0, second_spec[3:0]}) >= p1);
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          neg_q <= (req == REQ_DIVS) && (ds[WordBits-1] != vs[WordBits-1]);
          mask_q <= mask;
          if (ctl.go) begin
            state <= S_WAIT;
          end else begin
            if (is_alu && ((req == REQ_DIVU) || (req == REQ_DIVS))) dz <= 1'b1;
            else regs <= regs_next;
            state <= S_REPORT;
          end
        end
        S_WAIT: begin
          if (ser_done) begin
            regs <= slice_put(regs, s1, {{(RegBits-WordBits){1'b0}}, fin});
            state <= S_REPORT;
          end
        end
        S_REPORT: begin
          done <= 1'b1;
          divide_by_zero <= dz;
          read_data <= b1[WordBits-1:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_after_report: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_REPORT) else $error("done without report");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request accepted but not busy");
  a_dz_only_div: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (req == REQ_DIVU || req == REQ_DIVS))
    else $error("divide by zero flag on non divide");

endmodule

// ----- src/sfa_serial.sv -----
// bit-serial multiplier and restoring divider, one bit per cycle
module sfa_serial (
  input  logic                           clk,
  input  logic                           rst,
  input  sfa_pkg::sfa_ctl_t              ctl,
  input  logic [sfa_pkg::WordBits-1:0]   a,
  input  logic [sfa_pkg::WordBits-1:0]   b,
  output logic                           done,
  output logic [sfa_pkg::WordBits-1:0]   result
);
  import sfa_pkg::*;

  logic                 running;
  logic                 is_div;
  logic [CountBits-1:0] count;
  logic [WordBits-1:0]  x;
  logic [WordBits-1:0]  y;
  logic [WordBits:0]    acc;
  logic [WordBits:0]    rem_shift;
  logic [WordBits:0]    rem_diff;

  assign rem_shift = {acc[WordBits-1:0], x[WordBits-1]};
  assign rem_diff = rem_shift - {1'b0, y};
  assign result = is_div ? x : acc[WordBits-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.go) begin
        running <= 1'b1;
        is_div <= ctl.is_div;
        count <= '0;
        x <= a;
        y <= b;
        acc <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (is_div) begin
          if (!rem_diff[WordBits]) begin
            acc <= rem_diff;
            x <= {x[WordBits-2:0], 1'b1};
          end else begin
            acc <= rem_shift;
            x <= {x[WordBits-2:0], 1'b0};
          end
        end else begin
          if (y[0]) acc <= {1'b0, acc[WordBits-1:0] + x};
          x <= x << 1;
          y <= y >> 1;
        end
        if (count == CountBits'(WordBits - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
